### hdl/rass_pkg.sv
// Shared types and constants for the return address shadow stack.
// Depends on nothing; every other file imports it.
package rass_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int GUEST_W     = 32;
	localparam int HOST_W      = 48;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	typedef struct packed {
		logic [GUEST_W-1:0] guest;
		logic [HOST_W-1:0]  host;
	} rass_entry_t;

	// Shift command broadcast along the cell chain.
	typedef struct packed {
		logic push;
		logic pop;
	} rass_shift_t;

endpackage

### hdl/return_address_shadow_stack.sv
// Top level of the return address shadow stack: cell chain, fill count, result register.
// Depends on rass_pkg and rass_cell.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | operation[1:0], guest_addr[31:0],
//          |                     | host_target[47:0]
//  out     | out_valid/out_stall | hit, predicted_target[47:0]
//
// For each transaction the chain shifts and the result register loads at the same
// edge, so one operation per cycle is sustained while in_stall stays low.
// The result appears on the out channel on the cycle after acceptance.
// in_stall rises only while a finished result is held and out_stall is high.
// arst_n clears the fill count and the result valid; the cells hold no reset
// and are never read above the fill count.
module return_address_shadow_stack
	import rass_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [GUEST_W-1:0] guest_addr,
	input  logic [HOST_W-1:0]  host_target,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [HOST_W-1:0]  predicted_target
);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              out_valid_q;
	logic              hit_q;
	logic [HOST_W-1:0] target_q;

	logic              accept;
	logic              empty;
	logic              full;
	logic              top_match;
	rass_shift_t       shift;
	rass_entry_t       new_entry;
	rass_entry_t       cells [STACK_DEPTH];

	// Take a new transaction unless a result is waiting and the far side stalls.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(STACK_DEPTH));

	assign new_entry.guest = guest_addr;
	assign new_entry.host  = host_target;

	// Cell zero is the top of the stack.
	assign top_match = ~empty && (cells[0].guest == guest_addr) && (cells[0].host != '0);

	always_comb begin
		shift   = '0;
		count_d = count_q;
		if (accept) begin
			case (operation)
				OP_PUSH: begin
					shift.push = 1'b1;
					// A full stack is dropped and the new pair becomes its only entry.
					count_d = full ? CNT_W'(1) : count_q + CNT_W'(1);
				end
				OP_POP: begin
					if (!empty) begin
						shift.pop = 1'b1;
						count_d   = count_q - CNT_W'(1);
					end
				end
				OP_FLUSH: begin
					count_d = '0;
				end
				default: begin
					count_d = count_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		rass_entry_t above;
		rass_entry_t below;
		if (i == 0) begin : g_top
			assign above = new_entry;
		end else begin : g_mid
			assign above = cells[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			// Nothing lies below the last cell; hold its own contents.
			assign below = cells[i];
		end else begin : g_inner
			assign below = cells[i+1];
		end
		rass_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
				hit_q       <= (operation == OP_POP) && top_match;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the result register; only the hit flag needs a reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= ((operation == OP_POP) && top_match) ? cells[0].host : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign predicted_target = target_q;

endmodule

### hdl/rass_cell.sv
// One stack cell: holds a single guest/host pair and trades it with its neighbours.
// Depends on rass_pkg.
module rass_cell
	import rass_pkg::*;
(
	input  logic        clk,
	input  rass_shift_t shift,
	input  rass_entry_t from_above,
	input  rass_entry_t from_below,
	output rass_entry_t entry
);

	rass_entry_t entry_q;

	// Push moves entries away from the top, pop moves them towards it.
	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= from_above;
		end else if (shift.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

### hdl/rass_checker.sv
// Port-level checks for the return address shadow stack, bound to the top level.
// Depends on rass_pkg and return_address_shadow_stack.
module rass_checker
	import rass_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         operation,
	input logic [GUEST_W-1:0] guest_addr,
	input logic [HOST_W-1:0]  host_target,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic [HOST_W-1:0]  predicted_target
);

	logic in_acc;
	assign in_acc = in_valid & ~in_stall;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(predicted_target))
		else $error("stalled result changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> predicted_target == '0)
		else $error("miss carries nonzero target");

	a_non_pop_miss: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && operation != OP_POP |=> out_valid && !hit)
		else $error("non-pop transaction reported a hit");

	a_flush_then_pop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && operation == OP_FLUSH ##1 in_acc && operation == OP_POP |=> !hit)
		else $error("pop after flush hit");

	a_held_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("transaction taken while result held");

endmodule

bind return_address_shadow_stack rass_checker u_rass_checker (.*);
